// ===== hw/rtl/mei_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot escape iterator.
// No dependencies; used by every module of the block.
package mei_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ITER_BITS_DEF  = 16;

    localparam int FRAC_BITS = 26;
    localparam int MAG_BITS  = 40;

    // 4.0 in Q14.26
    localparam logic [MAG_BITS-1:0] FOUR_Q = MAG_BITS'(64'd4 << FRAC_BITS);

    // register indexes (paddr word address)
    localparam logic [2:0] REG_ITER_LIMIT = 3'd0;
    localparam logic [2:0] REG_RE_LEFT    = 3'd1;
    localparam logic [2:0] REG_IM_TOP     = 3'd2;
    localparam logic [2:0] REG_RE_STEP    = 3'd3;
    localparam logic [2:0] REG_IM_STEP    = 3'd4;
    localparam logic [2:0] REG_RADIUS_SQ  = 3'd5;
    localparam logic [2:0] REG_MODE       = 3'd6;
    localparam logic [2:0] REG_BLACK      = 3'd7;

    // reset values
    localparam logic [31:0] ITER_LIMIT_RST = 32'd256;
    localparam logic [31:0] RE_LEFT_RST    = 32'hF800_0000;
    localparam logic [31:0] IM_TOP_RST     = 32'h0600_0000;
    localparam logic [30:0] STEP_RST       = 31'h0003_0000;
    localparam logic [30:0] RADIUS_SQ_RST  = 31'h1000_0000;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_RADIUS = 1'b1;

    typedef struct packed {
        logic signed [31:0] re_left;
        logic signed [31:0] im_top;
        logic [30:0]        re_step;
        logic [30:0]        im_step;
        logic [30:0]        radius_sq;
        logic               mode;
        logic               blacken;
    } mei_cfg_t;

    typedef struct packed {
        logic load;     // take coordinates, form c
        logic iterate;  // advance z one step
        logic capture;  // latch the result fields
    } mei_cmd_t;

    typedef struct packed {
        logic finish;   // escape seen or limit reached on current z
    } mei_sts_t;

    // Clamp a sign-extended value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic ovf;
        ovf = !((&v[63:31]) || !(|v[63:31]));
        if (!ovf)
            sat32 = v[31:0];
        else if (v[63])
            sat32 = 32'sh8000_0000;
        else
            sat32 = 32'sh7FFF_FFFF;
    endfunction

endpackage

// ===== hw/rtl/mandelbrot_escape_iterator_unit.sv =====
// Mandelbrot escape iterator: one pixel in, one result beat out on done.
// One z = z^2 + c step per cycle runs in the datapath's square-and-add logic, from z = c
// until the escape test or the iteration limit ends the run and the result beat is
// registered with done. A new pixel is accepted in the cycle done is high, so a pixel is
// taken only once the last is through. done lasts one cycle; the receiver cannot stall.
// rst_n clears the controller and loads register defaults asynchronously.
module mandelbrot_escape_iterator_unit #(
    parameter int COORD_BITS = mei_pkg::COORD_BITS_DEF,
    parameter int ITER_BITS  = mei_pkg::ITER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic [COORD_BITS-1:0]         pixel_x,
    input  logic [COORD_BITS-1:0]         pixel_y,
    output logic                          done,
    output logic [COORD_BITS-1:0]         out_x,
    output logic [COORD_BITS-1:0]         out_y,
    output logic [ITER_BITS-1:0]          iterations,
    output logic                          escaped,
    output logic                          force_black,
    output logic [mei_pkg::MAG_BITS-1:0]  magnitude_sq
);

    mei_pkg::mei_cfg_t    cfg;
    mei_pkg::mei_cmd_t    cmd;
    mei_pkg::mei_sts_t    sts;
    logic [ITER_BITS-1:0] iter_limit;

    mei_regs #(
        .ITER_BITS (ITER_BITS)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .iter_limit (iter_limit),
        .cfg        (cfg)
    );

    mei_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    mei_datapath #(
        .COORD_BITS (COORD_BITS),
        .ITER_BITS  (ITER_BITS)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .sts          (sts),
        .cfg          (cfg),
        .iter_limit   (iter_limit),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .out_x        (out_x),
        .out_y        (out_y),
        .iterations   (iterations),
        .escaped      (escaped),
        .force_black  (force_black),
        .magnitude_sq (magnitude_sq)
    );

endmodule

// ===== hw/rtl/mei_regs.sv =====
// APB register file for the Mandelbrot escape iterator.
// Depends on mei_pkg for register indexes and reset values.
module mei_regs #(
    parameter int ITER_BITS = mei_pkg::ITER_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [ITER_BITS-1:0]  iter_limit,
    output mei_pkg::mei_cfg_t     cfg
);

    logic [ITER_BITS-1:0] iter_limit_reg;
    mei_pkg::mei_cfg_t    cfg_reg;
    logic                 wr_en;
    logic [2:0]           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_limit_reg     <= ITER_BITS'(mei_pkg::ITER_LIMIT_RST);
            cfg_reg.re_left    <= mei_pkg::RE_LEFT_RST;
            cfg_reg.im_top     <= mei_pkg::IM_TOP_RST;
            cfg_reg.re_step    <= mei_pkg::STEP_RST;
            cfg_reg.im_step    <= mei_pkg::STEP_RST;
            cfg_reg.radius_sq  <= mei_pkg::RADIUS_SQ_RST;
            cfg_reg.mode       <= mei_pkg::MODE_LINEAR;
            cfg_reg.blacken    <= 1'b1;
        end
        else if (wr_en)
        begin
            case (idx)
                mei_pkg::REG_ITER_LIMIT: iter_limit_reg     <= ITER_BITS'(pwdata & 32'h0000_FFFF);
                mei_pkg::REG_RE_LEFT:    cfg_reg.re_left    <= pwdata;
                mei_pkg::REG_IM_TOP:     cfg_reg.im_top     <= pwdata;
                mei_pkg::REG_RE_STEP:    cfg_reg.re_step    <= pwdata[30:0];
                mei_pkg::REG_IM_STEP:    cfg_reg.im_step    <= pwdata[30:0];
                mei_pkg::REG_RADIUS_SQ:  cfg_reg.radius_sq  <= pwdata[30:0];
                mei_pkg::REG_MODE:       cfg_reg.mode       <= pwdata[0];
                mei_pkg::REG_BLACK:      cfg_reg.blacken    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            mei_pkg::REG_ITER_LIMIT: prdata = 32'(iter_limit_reg);
            mei_pkg::REG_RE_LEFT:    prdata = cfg_reg.re_left;
            mei_pkg::REG_IM_TOP:     prdata = cfg_reg.im_top;
            mei_pkg::REG_RE_STEP:    prdata = {1'b0, cfg_reg.re_step};
            mei_pkg::REG_IM_STEP:    prdata = {1'b0, cfg_reg.im_step};
            mei_pkg::REG_RADIUS_SQ:  prdata = {1'b0, cfg_reg.radius_sq};
            mei_pkg::REG_MODE:       prdata = {31'd0, cfg_reg.mode};
            mei_pkg::REG_BLACK:      prdata = {31'd0, cfg_reg.blacken};
            default:                 prdata = 32'd0;
        endcase
    end

    assign iter_limit = iter_limit_reg;
    assign cfg        = cfg_reg;

endmodule

// ===== hw/rtl/mei_datapath.sv =====
// Datapath: point mapping, z = z^2 + c step, escape test and result registers.
// Depends on mei_pkg for config, command and status types.
module mei_datapath #(
    parameter int COORD_BITS = mei_pkg::COORD_BITS_DEF,
    parameter int ITER_BITS  = mei_pkg::ITER_BITS_DEF
) (
    input  logic                          clk,
    input  mei_pkg::mei_cmd_t             cmd,
    output mei_pkg::mei_sts_t             sts,
    input  mei_pkg::mei_cfg_t             cfg,
    input  logic [ITER_BITS-1:0]          iter_limit,
    input  logic [COORD_BITS-1:0]         pixel_x,
    input  logic [COORD_BITS-1:0]         pixel_y,
    output logic [COORD_BITS-1:0]         out_x,
    output logic [COORD_BITS-1:0]         out_y,
    output logic [ITER_BITS-1:0]          iterations,
    output logic                          escaped,
    output logic                          force_black,
    output logic [mei_pkg::MAG_BITS-1:0]  magnitude_sq
);

    localparam int CPW = COORD_BITS + 31;
    localparam int SW  = CPW + 2;
    localparam int MB  = mei_pkg::MAG_BITS;

    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic signed [31:0]    cr_reg, ci_reg, zr_reg, zi_reg;
    logic [ITER_BITS-1:0]  count_reg;

    logic [COORD_BITS-1:0] res_x_reg, res_y_reg;
    logic [ITER_BITS-1:0]  res_iter_reg;
    logic                  res_esc_reg, res_black_reg;
    logic [MB-1:0]         res_mag_reg;

    // point mapping
    logic [CPW-1:0]        xprod, yprod;
    logic signed [SW-1:0]  cr_sum, ci_sum;
    logic signed [31:0]    cr_sat, ci_sat;

    // iteration step
    logic signed [63:0]    prr, pii, pri;
    logic signed [37:0]    sr, si;
    logic signed [38:0]    twice_ri;
    logic signed [39:0]    nzr_w, nzi_w;
    logic signed [31:0]    nzr, nzi;
    logic [MB-1:0]         mag;
    logic                  esc_test, esc_hit, at_limit;

    assign xprod  = CPW'(pixel_x) * CPW'(cfg.re_step);
    assign yprod  = CPW'(pixel_y) * CPW'(cfg.im_step);
    assign cr_sum = SW'(cfg.re_left) + $signed(SW'(xprod));
    assign ci_sum = SW'(cfg.im_top) - $signed(SW'(yprod));
    assign cr_sat = mei_pkg::sat32(64'(cr_sum));
    assign ci_sat = mei_pkg::sat32(64'(ci_sum));

    assign prr = zr_reg * zr_reg;
    assign pii = zi_reg * zi_reg;
    assign pri = zr_reg * zi_reg;

    // floor by dropping fraction bits; 2*zr*zi drops one bit less
    assign sr       = prr[63:26];
    assign si       = pii[63:26];
    assign twice_ri = pri[63:25];

    assign nzr_w = 40'(sr) - 40'(si) + 40'(cr_reg);
    assign nzi_w = 40'(twice_ri) + 40'(ci_reg);
    assign nzr   = mei_pkg::sat32(64'(nzr_w));
    assign nzi   = mei_pkg::sat32(64'(nzi_w));

    // |z|^2 of the current z; both squares are non-negative and below 2^37
    assign mag = MB'(sr[36:0]) + MB'(si[36:0]);

    always_comb
    begin
        if (cfg.mode == mei_pkg::MODE_RADIUS)
            esc_test = (mag >= MB'(cfg.radius_sq));
        else
            esc_test = (mag > mei_pkg::FOUR_Q);
    end

    // the starting z = c is never tested
    assign esc_hit    = esc_test && (count_reg != '0);
    assign at_limit   = (count_reg == iter_limit);
    assign sts.finish = esc_hit || at_limit;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= pixel_x;
            y_reg     <= pixel_y;
            cr_reg    <= cr_sat;
            ci_reg    <= ci_sat;
            zr_reg    <= cr_sat;
            zi_reg    <= ci_sat;
            count_reg <= '0;
        end
        else if (cmd.iterate)
        begin
            zr_reg    <= nzr;
            zi_reg    <= nzi;
            count_reg <= count_reg + 1'b1;
        end

        if (cmd.capture)
        begin
            res_x_reg     <= x_reg;
            res_y_reg     <= y_reg;
            res_iter_reg  <= count_reg;
            res_esc_reg   <= esc_hit;
            res_black_reg <= cfg.blacken && !esc_hit;
            // a zero limit runs no step and reports zero magnitude
            res_mag_reg   <= (count_reg == '0) ? '0 : mag;
        end
    end

    assign out_x        = res_x_reg;
    assign out_y        = res_y_reg;
    assign iterations   = res_iter_reg;
    assign escaped      = res_esc_reg;
    assign force_black  = res_black_reg;
    assign magnitude_sq = res_mag_reg;

endmodule

// ===== hw/rtl/mei_ctrl.sv =====
// Controller state machine for the Mandelbrot escape iterator.
// Depends on mei_pkg for command and status types.
module mei_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output mei_pkg::mei_cmd_t  cmd,
    input  mei_pkg::mei_sts_t  sts
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   done_reg;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_RUN:
            begin
                cmd.capture = sts.finish;
                cmd.iterate = !sts.finish;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                        state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    // release as the result beat goes out
                    if (sts.finish)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done = done_reg;

endmodule

// ===== dv/mandelbrot_escape_iterator_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for mandelbrot_escape_iterator_unit: a directed pixel table,
// then random views. Depends on mei_pkg and the block's RTL only.
module mandelbrot_escape_iterator_unit_tb;

    localparam int COORD_W          = mei_pkg::COORD_BITS_DEF;
    localparam int ITER_W           = mei_pkg::ITER_BITS_DEF;
    localparam int MAG_W            = mei_pkg::MAG_BITS;
    localparam int STALL_LIMIT      = 200000;
    localparam int DIR_ROWS         = 23;
    localparam int RAND_PHASES      = 9;
    localparam int PIXELS_PER_PHASE = 50;
    localparam int REPORT_LIMIT     = 10;

    localparam longint S32_HI   = 64'sd2147483647;
    localparam longint S32_LO   = -64'sd2147483648;
    localparam longint MAG_CEIL = (64'sd1 <<< MAG_W) - 64'sd1;

    // how a directed row gets its expected result
    localparam logic PREDICT = 1'b0;
    localparam logic KNOWN   = 1'b1;

    localparam logic LIN = mei_pkg::MODE_LINEAR;
    localparam logic RAD = mei_pkg::MODE_RADIUS;

    typedef struct packed {
        logic [ITER_W-1:0] max_it;
        logic signed [31:0] re_left;
        logic signed [31:0] im_top;
        logic [30:0]        re_step;
        logic [30:0]        im_step;
        logic [30:0]        radius_sq;
        logic               mode;
        logic               black;
    } view_cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [ITER_W-1:0]   iter;
        logic                esc;
        logic                blk;
        logic [MAG_W-1:0]    mag;
    } pixel_result_t;

    typedef struct packed {
        logic [3:0]          sel;
        logic [COORD_W-1:0]  px;
        logic [COORD_W-1:0]  py;
        logic                known;
        logic [ITER_W-1:0]   iter;
        logic                esc;
        logic                blk;
        logic [MAG_W-1:0]    mag;
    } pixel_row_t;

    logic                clk;
    logic                rst_n   = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [4:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                start   = 1'b0;
    logic                busy;
    logic [COORD_W-1:0]  pixel_x = '0;
    logic [COORD_W-1:0]  pixel_y = '0;
    logic                done;
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic [ITER_W-1:0]   iterations;
    logic                escaped;
    logic                force_black;
    logic [MAG_W-1:0]    magnitude_sq;

    view_cfg_t     shadow;
    pixel_result_t pixel_q[$];
    pixel_result_t got;
    pixel_result_t want;
    int            mismatches   = 0;
    int            stall_cycles = 0;
    logic          quiet        = 1'b0;
    logic [3:0]    cur_sel;

    // max, re_left, im_top, re_step, im_step, radius_sq, mode, black
    view_cfg_t dir_view [0:9] = '{
        '{16'd256,   32'hF800_0000, 32'h0600_0000, 31'h0003_0000, 31'h0003_0000,
          31'h1000_0000, LIN, 1'b1},
        '{16'd0,     32'hF800_0000, 32'h0600_0000, 31'h0003_0000, 31'h0003_0000,
          31'h1000_0000, LIN, 1'b1},
        '{16'd16,    32'h0400_0000, 32'h0000_0000, 31'h0400_0000, 31'h0000_0000,
          31'h1000_0000, LIN, 1'b0},
        '{16'd16,    32'hF800_0000, 32'h0000_0000, 31'h0000_0000, 31'h0000_0000,
          31'h1000_0000, LIN, 1'b1},
        '{16'd16,    32'hF800_0000, 32'h0000_0000, 31'h0000_0000, 31'h0000_0000,
          31'h1000_0000, RAD, 1'b1},
        '{16'd16,    32'h0000_0000, 32'h0000_0000, 31'h0000_0000, 31'h0000_0000,
          31'h0000_0000, RAD, 1'b1},
        '{16'd65535, 32'h0000_0000, 32'h0000_0000, 31'h0000_0000, 31'h0000_0000,
          31'h1000_0000, LIN, 1'b0},
        '{16'd1,     32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
          31'h7FFF_FFFF, RAD, 1'b1},
        '{16'd65535, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_4000, 31'h0000_4000,
          31'h7FFF_FFFF, LIN, 1'b1},
        '{16'd64,    32'hFA00_0000, 32'h0400_0000, 31'h0000_A000, 31'h0000_A000,
          31'h7FFF_FFFF, RAD, 1'b0}
    };

    // sel, x, y, known, iterations, escaped, force_black, magnitude_sq
    pixel_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{4'd0, 12'd0,    12'd0,    KNOWN,   16'd1,     1'b1, 1'b0, 40'd1363148800},
        '{4'd0, 12'd4095, 12'd0,    PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        '{4'd0, 12'd0,    12'd4095, PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        '{4'd0, 12'd4095, 12'd4095, PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        '{4'd0, 12'd600,  12'd500,  PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        '{4'd0, 12'd2730, 12'd1365, PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        // zero iteration limit
        '{4'd1, 12'd1365, 12'd2730, KNOWN,   16'd0,     1'b0, 1'b1, 40'd0},
        '{4'd1, 12'd4095, 12'd4095, KNOWN,   16'd0,     1'b0, 1'b1, 40'd0},
        // c = 1 lands on exactly 4.0 first, which must not escape in linear mode
        '{4'd2, 12'd0,    12'd0,    KNOWN,   16'd2,     1'b1, 1'b0, 40'd1677721600},
        '{4'd2, 12'd1,    12'd4095, KNOWN,   16'd1,     1'b1, 1'b0, 40'd2415919104},
        // c = -2 sits on 4.0 forever
        '{4'd3, 12'd0,    12'd0,    KNOWN,   16'd16,    1'b0, 1'b1, 40'd268435456},
        '{4'd3, 12'd4095, 12'd4095, KNOWN,   16'd16,    1'b0, 1'b1, 40'd268435456},
        '{4'd4, 12'd0,    12'd0,    KNOWN,   16'd1,     1'b1, 1'b0, 40'd268435456},
        // zero radius escapes at once
        '{4'd5, 12'd4095, 12'd0,    KNOWN,   16'd1,     1'b1, 1'b0, 40'd0},
        '{4'd6, 12'd0,    12'd0,    KNOWN,   16'd65535, 1'b0, 1'b0, 40'd0},
        '{4'd7, 12'd0,    12'd0,    PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        '{4'd7, 12'd4095, 12'd4095, PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        '{4'd7, 12'd2048, 12'd1,    PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        '{4'd8, 12'd0,    12'd0,    PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        '{4'd8, 12'd4095, 12'd4095, PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        '{4'd9, 12'd2048, 12'd2048, PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        '{4'd9, 12'd1000, 12'd3000, PREDICT, 16'd0,     1'b0, 1'b0, 40'd0},
        '{4'd9, 12'd100,  12'd4000, PREDICT, 16'd0,     1'b0, 1'b0, 40'd0}
    };

    mandelbrot_escape_iterator_unit u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_s32(input longint v);
        if (v > S32_HI)
            return S32_HI;
        if (v < S32_LO)
            return S32_LO;
        return v;
    endfunction

    // Escape-time result of one pixel under view v.
    function automatic pixel_result_t escape_time(input logic [COORD_W-1:0] px,
                                                  input logic [COORD_W-1:0] py,
                                                  input view_cfg_t v);
        pixel_result_t r;
        longint cr, ci, zr, zi, zr_sq, zi_sq, mag;
        int unsigned n;
        r = '0;
        r.x = px;
        r.y = py;
        cr = clamp_s32(longint'(v.re_left) + longint'(px) * longint'(v.re_step));
        ci = clamp_s32(longint'(v.im_top) - longint'(py) * longint'(v.im_step));
        zr = cr;
        zi = ci;
        mag = 0;
        for (n = 1; n <= v.max_it && !r.esc; n++)
        begin
            zr_sq = (zr * zr) >>> mei_pkg::FRAC_BITS;
            zi_sq = (zi * zi) >>> mei_pkg::FRAC_BITS;
            zi = clamp_s32(((zr * zi) >>> (mei_pkg::FRAC_BITS - 1)) + ci);
            zr = clamp_s32(zr_sq - zi_sq + cr);
            mag = ((zr * zr) >>> mei_pkg::FRAC_BITS) + ((zi * zi) >>> mei_pkg::FRAC_BITS);
            if (mag > MAG_CEIL)
                mag = MAG_CEIL;
            r.iter = ITER_W'(n);
            if (v.mode == mei_pkg::MODE_RADIUS)
                r.esc = (mag >= longint'(v.radius_sq));
            else
                r.esc = (mag > longint'(mei_pkg::FOUR_Q));
        end
        r.mag = mag[MAG_W-1:0];
        r.blk = v.black & ~r.esc;
        return r;
    endfunction

    function automatic view_cfg_t random_view();
        view_cfg_t v;
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 6)
            v.max_it = ITER_W'($urandom_range(1, 40));
        else if (pick < 9)
            v.max_it = ITER_W'($urandom_range(41, 300));
        else
            v.max_it = ITER_W'(1);
        v.mode = 1'($urandom_range(1));
        v.black = 1'($urandom_range(1));
        if ($urandom_range(3) == 0)
            v.radius_sq = 31'($urandom);
        else
            v.radius_sq = 31'($urandom_range(32'h4000_0000));
        if ($urandom_range(4) == 0)
        begin
            v.re_left = $urandom;
            v.im_top = $urandom;
            v.re_step = 31'($urandom >> $urandom_range(31));
            v.im_step = 31'($urandom >> $urandom_range(31));
        end
        else
        begin
            // frame the set: real -2.5 .. -0.5 on the left, imaginary 0.5 .. 1.5 on top
            v.re_left = 32'hF600_0000 + $urandom_range(32'h0800_0000);
            v.im_top = 32'h0200_0000 + $urandom_range(32'h0400_0000);
            v.re_step = 31'($urandom_range(1024, 49152));
            v.im_step = 31'($urandom_range(1024, 49152));
        end
        return v;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
    endtask

    task automatic program_view(input view_cfg_t v);
        reg_write(mei_pkg::REG_ITER_LIMIT, 32'(v.max_it));
        reg_write(mei_pkg::REG_RE_LEFT, v.re_left);
        reg_write(mei_pkg::REG_IM_TOP, v.im_top);
        reg_write(mei_pkg::REG_RE_STEP, 32'(v.re_step));
        reg_write(mei_pkg::REG_IM_STEP, 32'(v.im_step));
        reg_write(mei_pkg::REG_RADIUS_SQ, 32'(v.radius_sq));
        reg_write(mei_pkg::REG_MODE, 32'(v.mode));
        reg_write(mei_pkg::REG_BLACK, 32'(v.black));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow = v;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
    endtask

    // Hold start high across back-to-back pixels; drop it only for an idle gap.
    task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                              input logic known, input pixel_result_t fixed);
        if (!quiet && $urandom_range(99) < 9)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        start <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        do @(posedge clk); while (busy !== 1'b0);
        pixel_q.push_back(known ? fixed : escape_time(px, py, shadow));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                got = {out_x, out_y, iterations, escaped, force_black, magnitude_sq};
                if (pixel_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result beat with nothing pending: pixel (%0d,%0d)",
                                 out_x, out_y);
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("want (%0d,%0d) iter %0d esc %b blk %b mag %0d",
                                     want.x, want.y, want.iter, want.esc, want.blk, want.mag);
                            $display(" got (%0d,%0d) iter %0d esc %b blk %b mag %0d",
                                     got.x, got.y, got.iter, got.esc, got.blk, got.mag);
                        end
                    end
                end
            end
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        pixel_result_t fixed;
        int sent;
        int r;
        int p;
        int k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first rows run on the reset values, no writes
        shadow = dir_view[0];
        cur_sel = 4'd0;
        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].sel != cur_sel)
            begin
                drain_results();
                program_view(dir_view[dir_rows[r].sel]);
                cur_sel = dir_rows[r].sel;
            end
            fixed = {dir_rows[r].px, dir_rows[r].py, dir_rows[r].iter,
                     dir_rows[r].esc, dir_rows[r].blk, dir_rows[r].mag};
            send_pixel(dir_rows[r].px, dir_rows[r].py, dir_rows[r].known, fixed);
        end

        sent = 0;
        for (p = 0; p < RAND_PHASES; p++)
        begin
            drain_results();
            program_view(random_view());
            for (k = 0; k < PIXELS_PER_PHASE; k++)
            begin
                quiet = (sent >= 150 && sent < 250);
                send_pixel(COORD_W'($urandom_range(4095)), COORD_W'($urandom_range(4095)),
                           PREDICT, '0);
                sent++;
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mei_pkg.sv
hw/rtl/mei_regs.sv
hw/rtl/mei_datapath.sv
hw/rtl/mei_ctrl.sv
hw/rtl/mandelbrot_escape_iterator_unit.sv
dv/mandelbrot_escape_iterator_unit_tb.sv
